>>> design/crc32fgc_pkg.sv
// ----------------------------------------------------------------------------
// crc32fgc_pkg
// Shared types, constants and the byte-wide reflected CRC update for the
// CRC-32 field generator and checker.
// ----------------------------------------------------------------------------
package crc32fgc_pkg;

  // reflected polynomials and all-ones init / final xor
  localparam logic [31:0] POLY_IEEE = 32'hEDB88320;
  localparam logic [31:0] POLY_CAST = 32'h82F63B78;
  localparam logic [31:0] CRC_ONES  = 32'hFFFFFFFF;

  // configuration port widths
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLY_SELECT = 1'b0,
    REG_CHECK_MODE  = 1'b1
  } reg_idx_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_SHORT    = 2'd2
  } status_t;

  // configuration settings seen by the datapath
  typedef struct packed {
    logic poly_select;
    logic check_mode;
  } cfg_t;

  // one byte through a reflected crc, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data,
                                           input logic [31:0] poly);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ poly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> design/crc32fgc_if.sv
// ----------------------------------------------------------------------------
// crc32fgc_if
// Valid/ready channels of the CRC-32 field generator and checker: frame
// bytes in, results out, and register writes.
// ----------------------------------------------------------------------------

// frame byte channel
interface crc32fgc_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source(output valid, output data_byte, output frame_end, input ready);
  modport sink(input valid, input data_byte, input frame_end, output ready);
endinterface

// result channel
interface crc32fgc_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;
  logic [1:0]  status;

  modport source(output valid, output crc_value, output status, input ready);
  modport sink(input valid, input crc_value, input status, output ready);
endinterface

// register write channel
interface crc32fgc_cfg_if import crc32fgc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

>>> design/crc32fgc_regs.sv
// ----------------------------------------------------------------------------
// crc32fgc_regs
// Configuration registers: polynomial select and check mode, written
// through the register write channel.
// ----------------------------------------------------------------------------
module crc32fgc_regs import crc32fgc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  crc32fgc_cfg_if.sink cfg,
  output cfg_t        settings
);

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      settings <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_POLY_SELECT: settings.poly_select <= cfg.data[0];
        REG_CHECK_MODE:  settings.check_mode  <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/crc32fgc_core.sv
// ----------------------------------------------------------------------------
// crc32fgc_core
// Input register, frame state and byte-wide CRC update, and the result
// register. One byte is consumed per cycle unless a frame end meets a full slot.
// ----------------------------------------------------------------------------
module crc32fgc_core import crc32fgc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             settings,
  crc32fgc_frame_if.sink   frame,
  crc32fgc_result_if.source result
);

  // input register
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_end;

  // frame state
  logic [31:0] running_crc;
  logic [2:0]  header_position;
  logic [31:0] stored_field;

  // next values
  logic [31:0] running_crc_next;
  logic [2:0]  header_position_next;
  logic [31:0] stored_field_next;
  logic [31:0] crc_final;
  status_t     status_next;
  logic [31:0] poly;
  logic        go;

  // a byte moves on unless it ends a frame and a full result slot is not taken
  assign go          = in_valid && (!in_end || !result.valid || result.ready);
  assign frame.ready = !in_valid || go;

  // capture the request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (frame.ready) begin
      in_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.ready && frame.valid) begin
      in_byte <= frame.data_byte;
      in_end  <= frame.frame_end;
    end
  end

  // field capture or crc update
  assign poly = settings.poly_select ? POLY_CAST : POLY_IEEE;

  always_comb begin
    running_crc_next     = running_crc;
    header_position_next = header_position;
    stored_field_next    = stored_field;
    if (!header_position[2]) begin
      stored_field_next    = {stored_field[23:0], in_byte};
      header_position_next = header_position + 3'd1;
    end else begin
      running_crc_next = crc_byte(running_crc, in_byte, poly);
    end
  end

  // result and status
  assign crc_final = running_crc_next ^ CRC_ONES;

  always_comb begin
    if (!header_position_next[2]) begin
      status_next = STATUS_SHORT;
    end else if (settings.check_mode && (crc_final != stored_field_next)) begin
      status_next = STATUS_MISMATCH;
    end else begin
      status_next = STATUS_OK;
    end
  end

  // frame state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc     <= CRC_ONES;
      header_position <= '0;
      stored_field    <= '0;
    end else if (go) begin
      if (in_end) begin
        running_crc     <= CRC_ONES;
        header_position <= '0;
        stored_field    <= '0;
      end else begin
        running_crc     <= running_crc_next;
        header_position <= header_position_next;
        stored_field    <= stored_field_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (go && in_end) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && in_end) begin
      result.crc_value <= crc_final;
      result.status    <= status_next;
    end
  end

endmodule

>>> design/crc32_field_generate_check.sv
// ----------------------------------------------------------------------------
// crc32_field_generate_check
// CRC-32 / CRC-32C field generator and checker over a byte stream.
// Result: the last byte goes from the input register to the result register.
// Throughput: one byte per cycle, set by the byte-wide crc update between
// the input register and frame state; a last byte waits on a full result slot.
// Reset: synchronous; valids, settings and field state zero, crc all ones.
// ----------------------------------------------------------------------------
module crc32_field_generate_check import crc32fgc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  crc32fgc_cfg_if.sink      cfg,
  crc32fgc_frame_if.sink    frame,
  crc32fgc_result_if.source result
);

  cfg_t settings;

  // configuration registers
  crc32fgc_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .settings (settings)
  );

  // crc datapath
  crc32fgc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .settings (settings),
    .frame    (frame),
    .result   (result)
  );

endmodule
